/* rtl/iqtr_pkg.sv */
// Shared constants, types and helper functions of the quarter-turn image rotator.
package iqtr_pkg;

    localparam int MAX_DIM     = 256;
    localparam int COORD_W     = $clog2(MAX_DIM);
    localparam int DIM_W       = COORD_W + 1;
    localparam int ADDR_W      = 2 * COORD_W;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int PIXEL_W     = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = DIM_W;

    typedef logic [DIM_W-1:0]   dim_t;
    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [PIXEL_W-1:0] pixel_t;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_QUARTER_TURNS = 3'd2,
        REG_WHOLE_IMAGE   = 3'd3,
        REG_SEL_LEFT      = 3'd4,
        REG_SEL_TOP       = 3'd5,
        REG_SEL_SIZE      = 3'd6
    } cfg_reg_t;

    // Clamped configuration as seen by the datapath
    typedef struct packed {
        dim_t       width;
        dim_t       height;
        logic [1:0] turns;
        logic       whole;
        coord_t     sel_left;
        coord_t     sel_top;
        dim_t       sel_size;
    } cfg_t;

    // Per-transaction source description leaving the sequencer
    typedef struct packed {
        logic   fetch;
        coord_t row;
        coord_t col;
        addr_t  load_addr;
        logic   frame_end;
    } src_t;

    typedef struct packed {
        dim_t r;
        dim_t c;
    } pos_t;

    function automatic dim_t clamp_dim(input dim_t v);
        dim_t res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = v;
        end
        return res;
    endfunction

    // Source position of output (i, j) for a clockwise turn of an h-by-w region
    function automatic pos_t turn_source(input logic [1:0] k, input dim_t h, input dim_t w,
                                         input dim_t i, input dim_t j);
        pos_t p;
        unique case (k)
            2'd1: begin
                p.r = h - DIM_W'(1) - j;
                p.c = i;
            end
            2'd2: begin
                p.r = h - DIM_W'(1) - i;
                p.c = w - DIM_W'(1) - j;
            end
            2'd3: begin
                p.r = j;
                p.c = w - DIM_W'(1) - i;
            end
            default: begin
                p.r = i;
                p.c = j;
            end
        endcase
        return p;
    endfunction

endpackage

/* rtl/iqtr_ram.sv */
// Generic single-port RAM with registered read data.
module iqtr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/iqtr_cfg.sv */
// Configuration register file with dimension clamping.
module iqtr_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                wr_en,
    input  logic [iqtr_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [iqtr_pkg::CFG_DATA_W-1:0]     wr_data,
    output iqtr_pkg::cfg_t                      cfg
);
    import iqtr_pkg::*;

    dim_t       width_reg;
    dim_t       height_reg;
    logic [1:0] turns_reg;
    logic       whole_reg;
    coord_t     left_reg;
    coord_t     top_reg;
    dim_t       size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
            turns_reg  <= 2'd0;
            whole_reg  <= 1'b1;
            left_reg   <= '0;
            top_reg    <= '0;
            size_reg   <= DIM_W'(1);
        end else if (wr_en) begin
            unique case (cfg_reg_t'(wr_index))
                REG_IMAGE_WIDTH:   width_reg  <= wr_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT:  height_reg <= wr_data[DIM_W-1:0];
                REG_QUARTER_TURNS: turns_reg  <= wr_data[1:0];
                REG_WHOLE_IMAGE:   whole_reg  <= wr_data[0];
                REG_SEL_LEFT:      left_reg   <= wr_data[COORD_W-1:0];
                REG_SEL_TOP:       top_reg    <= wr_data[COORD_W-1:0];
                REG_SEL_SIZE:      size_reg   <= wr_data[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.width    = clamp_dim(width_reg);
        cfg.height   = clamp_dim(height_reg);
        cfg.turns    = turns_reg;
        cfg.whole    = whole_reg;
        cfg.sel_left = left_reg;
        cfg.sel_top  = top_reg;
        cfg.sel_size = clamp_dim(size_reg);
    end

endmodule

/* rtl/iqtr_seq.sv */
// Load and fetch counters with source-position mapping for each transaction.
module iqtr_seq (
    input  logic           aclk,
    input  logic           aresetn,
    input  iqtr_pkg::cfg_t cfg,
    input  logic           accept,
    input  logic           func,
    output iqtr_pkg::src_t src
);
    import iqtr_pkg::*;

    addr_t  load_index_reg, load_index_next;
    coord_t out_row_reg, out_row_next;
    coord_t out_col_reg, out_col_next;

    logic [2*DIM_W-1:0] total;
    logic [ADDR_W:0]    load_inc;
    logic               odd;
    dim_t               ow, oh;
    logic               wrap;
    dim_t               row9, col9;
    dim_t               top9, left9;
    logic [DIM_W:0]     sel_bottom, sel_right;
    logic               fits, in_sel;
    pos_t               whole_pos, local_pos;
    dim_t               src_r, src_c;
    logic [DIM_W:0]     row_inc, col_inc;

    always_comb begin
        total    = cfg.width * cfg.height;
        load_inc = {1'b0, load_index_reg} + (ADDR_W + 1)'(1);

        odd  = cfg.whole & cfg.turns[0];
        ow   = odd ? cfg.height : cfg.width;
        oh   = odd ? cfg.width : cfg.height;
        wrap = ({1'b0, out_row_reg} >= oh) || ({1'b0, out_col_reg} >= ow);
        row9 = wrap ? '0 : {1'b0, out_row_reg};
        col9 = wrap ? '0 : {1'b0, out_col_reg};

        top9       = {1'b0, cfg.sel_top};
        left9      = {1'b0, cfg.sel_left};
        sel_bottom = {1'b0, top9} + {1'b0, cfg.sel_size};
        sel_right  = {1'b0, left9} + {1'b0, cfg.sel_size};
        fits       = (sel_right <= {1'b0, cfg.width}) && (sel_bottom <= {1'b0, cfg.height});
        in_sel     = fits && (row9 >= top9) && ({1'b0, row9} < sel_bottom)
                     && (col9 >= left9) && ({1'b0, col9} < sel_right);

        whole_pos = turn_source(cfg.turns, cfg.height, cfg.width, row9, col9);
        local_pos = turn_source(cfg.turns, cfg.sel_size, cfg.sel_size,
                                row9 - top9, col9 - left9);

        if (cfg.whole) begin
            src_r = whole_pos.r;
            src_c = whole_pos.c;
        end else if (in_sel) begin
            src_r = local_pos.r + top9;
            src_c = local_pos.c + left9;
        end else begin
            src_r = row9;
            src_c = col9;
        end

        src.fetch     = (func == FUNC_FETCH);
        src.row       = src_r[COORD_W-1:0];
        src.col       = src_c[COORD_W-1:0];
        src.load_addr = load_index_reg;
        src.frame_end = (row9 == oh - DIM_W'(1)) && (col9 == ow - DIM_W'(1));

        row_inc = {1'b0, row9} + (DIM_W + 1)'(1);
        col_inc = {1'b0, col9} + (DIM_W + 1)'(1);

        load_index_next = load_index_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        if (accept) begin
            if (func == FUNC_LOAD) begin
                load_index_next = ({1'b0, load_inc} >= total) ? '0 : load_inc[ADDR_W-1:0];
            end else if (col_inc >= {1'b0, ow}) begin
                out_col_next = '0;
                out_row_next = (row_inc >= {1'b0, oh}) ? '0 : row_inc[COORD_W-1:0];
            end else begin
                out_row_next = row9[COORD_W-1:0];
                out_col_next = col_inc[COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_index_reg <= '0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
        end else begin
            load_index_reg <= load_index_next;
            out_row_reg    <= out_row_next;
            out_col_reg    <= out_col_next;
        end
    end

endmodule

/* rtl/image_quarter_turn_rotator.sv */
// Top level of the quarter-turn image rotator: frame store and transaction pipeline.
//
//   Channel  Handshake              Payload
//   s_       s_valid / s_ready      s_func, s_pixel_in
//   m_       m_valid / m_ready      m_pixel_out, m_frame_end
//   cfg_     cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One transaction per cycle while the output is not stalled. The path is: counters
// and source mapping (s1_reg), row-times-width address multiply (addr2_reg), then
// one frame store access whose registered read data is the result. A load
// produces no result.
// aresetn is synchronous, active low; the frame store is not cleared.
// A stalled result holds output and a fetch behind it; loads and bubbles still move.
module image_quarter_turn_rotator (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_func,
    input  logic [iqtr_pkg::PIXEL_W-1:0]    s_pixel_in,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [iqtr_pkg::PIXEL_W-1:0]    m_pixel_out,
    output logic                            m_frame_end,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [iqtr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [iqtr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import iqtr_pkg::*;

    cfg_t   cfg;
    src_t   src;
    logic   accept;

    logic   v1_reg, v1_next;
    src_t   s1_reg;
    pixel_t pix1_reg;

    logic   v2_reg, v2_next;
    logic   fetch2_reg;
    addr_t  addr2_reg;
    pixel_t pix2_reg;
    logic   end2_reg;

    logic   o_valid_reg, o_valid_next;
    logic   o_end_reg;

    logic   s3_free, go2, free2, free1, move12;
    logic [COORD_W+DIM_W-1:0] prod;
    logic [COORD_W+DIM_W:0]   fetch_addr;
    logic   ram_we, ram_re;
    pixel_t ram_rdata;

    assign cfg_ready = 1'b1;

    iqtr_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    iqtr_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .accept  (accept),
        .func    (s_func),
        .src     (src)
    );

    always_comb begin
        s3_free = !o_valid_reg || m_ready;
        go2     = v2_reg && (!fetch2_reg || s3_free);
        free2   = !v2_reg || go2;
        free1   = !v1_reg || free2;
        move12  = v1_reg && free2;
        s_ready = free1;
        accept  = s_valid && free1;

        prod       = s1_reg.row * cfg.width;
        fetch_addr = {1'b0, prod} + (COORD_W + DIM_W + 1)'(s1_reg.col);

        v1_next      = accept || (v1_reg && !free2);
        v2_next      = move12 || (v2_reg && !go2);
        o_valid_next = s3_free ? (v2_reg && fetch2_reg) : o_valid_reg;

        ram_we = v2_reg && !fetch2_reg;
        ram_re = v2_reg && fetch2_reg && s3_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg   <= src;
            pix1_reg <= s_pixel_in;
        end
        if (move12) begin
            fetch2_reg <= s1_reg.fetch;
            addr2_reg  <= s1_reg.fetch ? fetch_addr[ADDR_W-1:0] : s1_reg.load_addr;
            pix2_reg   <= pix1_reg;
            end2_reg   <= s1_reg.frame_end;
        end
        if (ram_re) begin
            o_end_reg <= end2_reg;
        end
    end

    iqtr_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (STORE_DEPTH)
    ) u_frame_store (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (addr2_reg),
        .wdata (pix2_reg),
        .rdata (ram_rdata)
    );

    assign m_valid     = o_valid_reg;
    assign m_pixel_out = ram_rdata;
    assign m_frame_end = o_end_reg;

endmodule

/* test/testbench.sv */
// Testbench for the quarter-turn image rotator: queued loads and fetches against a predictor.
module testbench;
    import iqtr_pkg::*;

    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int RANDOM_ITEMS     = 650;

    typedef struct {
        logic   func;
        pixel_t pixel;
    } pixel_job_t;

    typedef struct {
        pixel_t pixel;
        logic   frame_end;
    } rotated_px_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic                  s_func      = FUNC_LOAD;
    pixel_t                s_pixel_in  = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    pixel_t                m_pixel_out;
    logic                  m_frame_end;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    pixel_job_t  pixel_jobs[$];
    rotated_px_t expected_pixels[$];

    pixel_t     frame_mem [STORE_DEPTH];
    bit         frame_loaded [STORE_DEPTH];
    int         load_ptr   = 0;
    int         out_r      = 0;
    int         out_c      = 0;
    logic [8:0] reg_width  = 9'd1;
    logic [8:0] reg_height = 9'd1;
    logic [1:0] reg_turns  = 2'd0;
    logic       reg_whole  = 1'b1;
    logic [7:0] reg_left   = 8'd0;
    logic [7:0] reg_top    = 8'd0;
    logic [8:0] reg_size   = 9'd1;

    int send_gap      = 0;
    int hold_cnt      = 0;
    bit long_hold_req = 1'b0;
    bit idle_en       = 1'b1;
    int errors        = 0;
    int items_sent    = 0;

    image_quarter_turn_rotator uut (.*);

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int eff_dim(input logic [8:0] v);
        if (v == 9'd0) begin
            return 1;
        end
        if (v > MAX_DIM) begin
            return MAX_DIM;
        end
        return int'(v);
    endfunction

    function automatic void turn_back(input int k, input int h, input int w, input int i,
                                      input int j, output int r, output int c);
        case (k)
            1: begin
                r = h - 1 - j;
                c = i;
            end
            2: begin
                r = h - 1 - i;
                c = w - 1 - j;
            end
            3: begin
                r = j;
                c = w - 1 - i;
            end
            default: begin
                r = i;
                c = j;
            end
        endcase
    endfunction

    function automatic void predict_rotation(input logic func, input pixel_t pix);
        int w, h, ow, oh, r, c, s, lr, lc;
        bit fits;
        rotated_px_t res;
        w = eff_dim(reg_width);
        h = eff_dim(reg_height);
        if (func == FUNC_LOAD) begin
            frame_mem[load_ptr % STORE_DEPTH] = pix;
            frame_loaded[load_ptr % STORE_DEPTH] = 1'b1;
            load_ptr = (load_ptr + 1 >= w * h) ? 0 : load_ptr + 1;
        end else begin
            ow = w;
            oh = h;
            if (reg_whole && reg_turns[0]) begin
                ow = h;
                oh = w;
            end
            if (out_r >= oh || out_c >= ow) begin
                out_r = 0;
                out_c = 0;
            end
            r = out_r;
            c = out_c;
            if (reg_whole) begin
                turn_back(int'(reg_turns), h, w, out_r, out_c, r, c);
            end else begin
                s = eff_dim(reg_size);
                fits = (int'(reg_left) + s <= w) && (int'(reg_top) + s <= h);
                if (fits && out_r >= int'(reg_top) && out_r < int'(reg_top) + s &&
                    out_c >= int'(reg_left) && out_c < int'(reg_left) + s) begin
                    turn_back(int'(reg_turns), s, s, out_r - int'(reg_top),
                              out_c - int'(reg_left), lr, lc);
                    r = lr + int'(reg_top);
                    c = lc + int'(reg_left);
                end
            end
            res.pixel = frame_mem[(r * w + c) % STORE_DEPTH];
            res.frame_end = (out_r == oh - 1) && (out_c == ow - 1);
            expected_pixels.push_back(res);
            if (out_c + 1 >= ow) begin
                out_c = 0;
                out_r = (out_r + 1 >= oh) ? 0 : out_r + 1;
            end else begin
                out_c = out_c + 1;
            end
        end
    endfunction

    function automatic void apply_reg(input cfg_reg_t idx, input logic [8:0] v);
        case (idx)
            REG_IMAGE_WIDTH:   reg_width  = v;
            REG_IMAGE_HEIGHT:  reg_height = v;
            REG_QUARTER_TURNS: reg_turns  = v[1:0];
            REG_WHOLE_IMAGE:   reg_whole  = v[0];
            REG_SEL_LEFT:      reg_left   = v[7:0];
            REG_SEL_TOP:       reg_top    = v[7:0];
            REG_SEL_SIZE:      reg_size   = v;
            default: ;
        endcase
    endfunction

    function automatic bit frame_ready(input int total);
        for (int a = 0; a < total; a++) begin
            if (!frame_loaded[a]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic int extreme_dim();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 256;
            2: return 257;
            default: return 511;
        endcase
    endfunction

    always @(posedge aclk) begin : driver
        pixel_job_t job;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_rotation(s_func, s_pixel_in);
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    s_valid <= 1'b0;
                end else if (pixel_jobs.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (idle_en && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(1, 6) - 1;
                    s_valid <= 1'b0;
                end else begin
                    job = pixel_jobs.pop_front();
                    s_valid    <= 1'b1;
                    s_func     <= job.func;
                    s_pixel_in <= job.pixel;
                end
            end
        end
    end

    always @(posedge aclk) begin : monitor
        rotated_px_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    errors = errors + 1;
                    $display("%0t: unexpected transaction, expected none, actual pixel %h end %b",
                             $time, m_pixel_out, m_frame_end);
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_pixel_out !== want.pixel) begin
                        errors = errors + 1;
                        $display("%0t: pixel_out expected %h actual %h",
                                 $time, want.pixel, m_pixel_out);
                    end
                    if (m_frame_end !== want.frame_end) begin
                        errors = errors + 1;
                        $display("%0t: frame_end expected %b actual %b",
                                 $time, want.frame_end, m_frame_end);
                    end
                end
            end
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_cnt = LONG_HOLD_CYCLES;
                m_ready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt = hold_cnt - 1;
                m_ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                hold_cnt = $urandom_range(1, 6) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic add_job(input logic func, input pixel_t pix);
        pixel_job_t j;
        j.func  = func;
        j.pixel = pix;
        pixel_jobs.push_back(j);
        items_sent = items_sent + 1;
    endtask

    task automatic wait_idle();
        while (pixel_jobs.size() != 0 || s_valid || expected_pixels.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        apply_reg(idx, value[CFG_DATA_W-1:0]);
    endtask

    task automatic run_phase(input int wv, input int hv, input int kv, input int wholev,
                             input int leftv, input int topv, input int sizev,
                             input int n_items, input int load_pct, input bit long_hold);
        int total;
        write_reg(REG_IMAGE_WIDTH, wv);
        write_reg(REG_IMAGE_HEIGHT, hv);
        write_reg(REG_QUARTER_TURNS, kv);
        write_reg(REG_WHOLE_IMAGE, wholev);
        write_reg(REG_SEL_LEFT, leftv);
        write_reg(REG_SEL_TOP, topv);
        write_reg(REG_SEL_SIZE, sizev);
        cfg_valid <= 1'b0;
        total = eff_dim(reg_width) * eff_dim(reg_height);
        // fill every frame address before any fetch can read it
        if (!frame_ready(total)) begin
            repeat ((load_ptr >= total) ? total + 1 : total) begin
                add_job(FUNC_LOAD, pixel_t'($urandom));
            end
        end
        repeat (n_items) begin
            add_job(($urandom_range(0, 99) < load_pct) ? FUNC_LOAD : FUNC_FETCH,
                    pixel_t'($urandom));
        end
        if (long_hold) begin
            long_hold_req = 1'b1;
        end
        wait_idle();
    endtask

    task automatic random_phase(input bit quiet);
        int wv, hv, ew, eh, leftv, topv, sizev, pick, n_cap;
        pick = $urandom_range(0, 9);
        wv = $urandom_range(1, 8);
        hv = $urandom_range(1, 8);
        if (pick == 0) begin
            wv = extreme_dim();
            hv = $urandom_range(1, 2);
        end else if (pick == 1) begin
            hv = extreme_dim();
            wv = $urandom_range(1, 2);
        end
        ew = eff_dim(wv[8:0]);
        eh = eff_dim(hv[8:0]);
        if ($urandom_range(0, 4) == 0) begin
            leftv = $urandom_range(0, 511);
            topv  = $urandom_range(0, 511);
            sizev = $urandom_range(0, 511);
        end else begin
            sizev = $urandom_range(1, (ew < eh) ? ew : eh);
            leftv = $urandom_range(0, ew - sizev);
            topv  = $urandom_range(0, eh - sizev);
        end
        n_cap = (2 * ew * eh + 2 < 48) ? 2 * ew * eh + 2 : 48;
        idle_en = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
        run_phase(wv, hv, $urandom_range(0, 3), $urandom_range(0, 1), leftv, topv, sizev,
                  $urandom_range(1, n_cap), $urandom_range(0, 20), 1'b0);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset setting: single-pixel frame, no turn
        add_job(FUNC_LOAD, 24'hFFFFFF);
        add_job(FUNC_FETCH, 24'h000000);
        add_job(FUNC_FETCH, 24'hFFFFFF);
        add_job(FUNC_LOAD, 24'h000000);
        add_job(FUNC_FETCH, 24'h5A5A5A);
        wait_idle();

        run_phase(3, 2, 1, 1, 0, 0, 2, 7, 0, 1'b0);
        run_phase(3, 2, 3, 0, 1, 0, 2, 6, 0, 1'b0);
        run_phase(4, 4, 2, 0, 1, 1, 2, 16, 0, 1'b0);
        run_phase(4, 4, 1, 0, 0, 0, 4, 16, 0, 1'b0);
        run_phase(4, 4, 1, 0, 0, 0, 511, 16, 0, 1'b0);
        run_phase(0, 0, 2, 1, 511, 511, 0, 3, 10, 1'b0);
        run_phase(5, 3, 2, 0, 3, 1, 3, 15, 0, 1'b0);

        // hold the receiver while fetches keep coming
        run_phase(4, 4, 2, 1, 0, 0, 1, 48, 0, 1'b1);

        run_phase(511, 2, 2, 0, 0, 0, 2, 24, 0, 1'b0);
        run_phase(1, 511, 3, 1, 0, 0, 1, 20, 0, 1'b0);

        while (items_sent < RANDOM_ITEMS) begin
            random_phase(1'b0);
        end
        repeat (3) random_phase(1'b1);

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/iqtr_pkg.sv
rtl/iqtr_ram.sv
rtl/iqtr_cfg.sv
rtl/iqtr_seq.sv
rtl/image_quarter_turn_rotator.sv
test/testbench.sv
